// ===== design/flight_path_vector_angles_macros.svh =====
// Assertion macros for the flight path vector angles block.
`ifndef FLIGHT_PATH_VECTOR_ANGLES_MACROS_SVH
`define FLIGHT_PATH_VECTOR_ANGLES_MACROS_SVH

// cond must hold at every edge out of reset
`define FPVA_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fpva: invariant violated");

// cons must hold in the cycle after ante
`define FPVA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpva: sequence violated");

`endif

// ===== design/fpva_pkg.sv =====
// Shared widths, limits and the CORDIC arctangent table for the flight path vector angles block.
package fpva_pkg;

  localparam int GS_W        = 18;
  localparam int VS_W        = 17;
  localparam int ANG_W       = 16;
  localparam int DRIFT_W     = 15;
  localparam int PITCH_W     = 14;
  localparam int HDG_W       = 15;
  localparam int XY_W        = 34;
  localparam int Z_W         = 32;
  localparam int RND_SH      = 16;
  localparam int RND_W       = Z_W - RND_SH;
  localparam int ATAN_W      = 28;
  localparam int MAX_STEPS   = 24;
  localparam int PRESCALE_SH = 12;

  localparam logic [GS_W-1:0]          GS_FLOOR    = 18'd26;
  localparam logic signed [VS_W-1:0]   VS_LIMIT    = 17'sd25600;
  localparam logic signed [ANG_W:0]    FULL_TURN   = 17'sd23040;
  localparam logic signed [ANG_W:0]    TWO_TURNS   = 17'sd46080;
  localparam logic signed [ANG_W-1:0]  HALF_TURN_D = 16'sd11520;
  localparam logic signed [ANG_W-1:0]  FULL_TURN_D = 16'sd23040;
  localparam logic signed [RND_W-1:0]  PITCH_LIMIT = 16'sd5760;
  localparam logic signed [Z_W-1:0]    ROUND_HALF  = 32'sd32768;

  // atan(2^-i) in units of 2^-22 degree
  localparam logic [ATAN_W-1:0] ATAN_TAB [MAX_STEPS] = '{
    28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485,
    28'd15000234,  28'd7507429,   28'd3754631,  28'd1877430,
    28'd938729,    28'd469366,    28'd234683,   28'd117342,
    28'd58671,     28'd29335,     28'd14668,    28'd7334,
    28'd3667,      28'd1833,      28'd917,      28'd458,
    28'd229,       28'd115,       28'd57,       28'd29
  };

  typedef struct packed {
    logic [GS_W-1:0]  gs;
    logic [HDG_W-1:0] hdg;
    logic [HDG_W-1:0] trk;
  } fpva_side_t;

endpackage

// ===== design/fpva_in_if.sv =====
// Input channel: one air data sample per beat.
interface fpva_in_if import fpva_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [GS_W-1:0]         ground_speed;
  logic signed [VS_W-1:0]  climb_rate;
  logic signed [ANG_W-1:0] heading_true;
  logic signed [ANG_W-1:0] track_true;

  modport source (output valid, ground_speed, climb_rate, heading_true, track_true,
                  input ready);
  modport sink (input valid, ground_speed, climb_rate, heading_true, track_true,
                output ready);
endinterface

// ===== design/fpva_out_if.sv =====
// Output channel: flight path angles, one result per beat.
interface fpva_out_if import fpva_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIFT_W-1:0] drift_out;
  logic signed [PITCH_W-1:0] path_pitch;
  logic [HDG_W-1:0]          path_heading;
  logic [GS_W-1:0]           speed_used;

  modport source (output valid, drift_out, path_pitch, path_heading, speed_used,
                  input ready);
  modport sink (input valid, drift_out, path_pitch, path_heading, speed_used,
                output ready);
endinterface

// ===== design/flight_path_vector_angles.sv =====
// Flight path vector angles: drift, wrapped track and CORDIC flight path pitch.
//
//   channel   dir   handshake      beat contents
//   sample    in    valid/ready    ground_speed, climb_rate, heading_true, track_true
//   result    out   valid/ready    drift_out, path_pitch, path_heading, speed_used
//
// One beat per cycle sustained unless result stalls; CORDIC_STEPS is capped at 24 and
// the pipeline has an input conditioning stage, one register stage per CORDIC iteration,
// and an output stage that rounds the angle and folds the drift.
// Synchronous active-high reset clears the stage valid bits and holds sample ready low.
// Each stage loads when it is empty or its successor moves, so bubbles
// close up, and a stalled result holds in place each full stage with no empty stage after it.
`include "flight_path_vector_angles_macros.svh"

module flight_path_vector_angles import fpva_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input logic        clk,
  input logic        rst,
  fpva_in_if.sink    sample,
  fpva_out_if.source result
);

  localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  logic                   vld  [STEPS+1];
  logic signed [XY_W-1:0] x    [STEPS+1];
  logic signed [XY_W-1:0] y    [STEPS+1];
  logic signed [Z_W-1:0]  z    [STEPS+1];
  fpva_side_t             side [STEPS+1];
  logic                   adv  [STEPS+2];

  function automatic logic [HDG_W-1:0] wrap_turn(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W:0] v;
    logic signed [ANG_W:0] r;
    v = {a[ANG_W-1], a};
    if (v < -FULL_TURN) begin
      r = v + TWO_TURNS;
    end else if (v < 0) begin
      r = v + FULL_TURN;
    end else if (v >= FULL_TURN) begin
      r = v - FULL_TURN;
    end else begin
      r = v;
    end
    return r[HDG_W-1:0];
  endfunction

  // ready chain
  assign adv[STEPS+1] = !result.valid || result.ready;
  for (genvar s = 0; s <= STEPS; s++) begin : g_adv
    assign adv[s] = !vld[s] || adv[s+1];
  end
  assign sample.ready = adv[0] && !rst;

  // input conditioning
  logic [GS_W-1:0]        gs_fl;
  logic signed [VS_W-1:0] vs_cl;

  always_comb begin
    gs_fl = (sample.ground_speed < GS_FLOOR) ? GS_FLOOR : sample.ground_speed;
    if (sample.climb_rate > VS_LIMIT) begin
      vs_cl = VS_LIMIT;
    end else if (sample.climb_rate < -VS_LIMIT) begin
      vs_cl = -VS_LIMIT;
    end else begin
      vs_cl = sample.climb_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x[0]        <= signed'({{(XY_W-GS_W-PRESCALE_SH){1'b0}}, gs_fl,
                              {PRESCALE_SH{1'b0}}});
      y[0]        <= {{(XY_W-VS_W-PRESCALE_SH){vs_cl[VS_W-1]}}, vs_cl,
                      {PRESCALE_SH{1'b0}}};
      z[0]        <= '0;
      side[0].gs  <= gs_fl;
      side[0].hdg <= wrap_turn(sample.heading_true);
      side[0].trk <= wrap_turn(sample.track_true);
    end
  end

  // CORDIC vectoring iterations, one per stage
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic signed [XY_W-1:0] xs, ys, nx, ny;
    logic signed [Z_W-1:0]  ang, nz;

    always_comb begin
      xs  = x[s] >>> s;
      ys  = y[s] >>> s;
      ang = signed'({{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[s]});
      if (!y[s][XY_W-1]) begin
        nx = x[s] + ys;
        ny = y[s] - xs;
        nz = z[s] + ang;
      end else begin
        nx = x[s] - ys;
        ny = y[s] + xs;
        nz = z[s] - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv[s+1]) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s+1]) begin
        x[s+1]    <= nx;
        y[s+1]    <= ny;
        z[s+1]    <= nz;
        side[s+1] <= side[s];
      end
    end
  end

  // output stage: round angle, clamp, fold drift
  logic signed [Z_W-1:0]     z_rnd;
  logic signed [RND_W-1:0]   p_rnd;
  logic signed [PITCH_W-1:0] pitch;
  logic signed [ANG_W-1:0]   d_raw;
  logic signed [ANG_W-1:0]   d_fold;

  always_comb begin
    z_rnd = z[STEPS] + ROUND_HALF;
    p_rnd = z_rnd[Z_W-1:RND_SH];
    if (p_rnd > PITCH_LIMIT) begin
      pitch = PITCH_LIMIT[PITCH_W-1:0];
    end else if (p_rnd < -PITCH_LIMIT) begin
      pitch = PITCH_W'(-PITCH_LIMIT);
    end else begin
      pitch = p_rnd[PITCH_W-1:0];
    end
    d_raw = signed'({1'b0, side[STEPS].trk}) - signed'({1'b0, side[STEPS].hdg});
    if (d_raw > HALF_TURN_D) begin
      d_fold = d_raw - FULL_TURN_D;
    end else if (d_raw < -HALF_TURN_D) begin
      d_fold = d_raw + FULL_TURN_D;
    end else begin
      d_fold = d_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv[STEPS+1]) begin
      result.valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[STEPS+1]) begin
      result.drift_out    <= d_fold[DRIFT_W-1:0];
      result.path_pitch   <= pitch;
      result.path_heading <= side[STEPS].trk;
      result.speed_used   <= side[STEPS].gs;
    end
  end

  logic pitch_in_range;
  logic spd_hdg_in_range;

  assign pitch_in_range   = (result.path_pitch <= PITCH_LIMIT) &&
                            (result.path_pitch >= -PITCH_LIMIT);
  assign spd_hdg_in_range = (result.speed_used >= GS_FLOOR) &&
                            (result.path_heading < FULL_TURN[HDG_W-1:0]);

  `FPVA_ASSERT_ALWAYS(a_pitch_range, !result.valid || pitch_in_range)
  `FPVA_ASSERT_ALWAYS(a_speed_hdg_range, !result.valid || spd_hdg_in_range)
  `FPVA_ASSERT_NEXT(a_last_stage_held, vld[STEPS] && !adv[STEPS+1], vld[STEPS])

endmodule
